// ----- hdl/fcull_pkg.sv -----
`default_nettype none
package fcull_pkg;

    localparam int NUM_PLANES = 6;
    localparam int FRAC_BITS  = 16;
    localparam int COORD_W    = 32;
    localparam int PROD_W     = 2 * COORD_W;
    localparam int ACC_W      = PROD_W + 4;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_POINT  = 2'd1;
    localparam logic [1:0] CMD_SPHERE = 2'd2;
    localparam logic [1:0] CMD_BOX    = 2'd3;

    localparam logic [2:0] NONE_CODE = 3'(NUM_PLANES);

    typedef struct packed {
        logic [1:0]                 command;
        logic [2:0]                 plane_index;
        logic signed [COORD_W-1:0]  ax;
        logic signed [COORD_W-1:0]  ay;
        logic signed [COORD_W-1:0]  az;
        logic signed [COORD_W-1:0]  bx;
        logic signed [COORD_W-1:0]  by;
        logic signed [COORD_W-1:0]  bz;
        logic signed [COORD_W-1:0]  scalar;
        logic                       box_null;
    } t_req;

    typedef struct packed {
        logic visible;
        logic [2:0] culled_plane;
    } t_res;

endpackage
`default_nettype wire

// ----- hdl/frustum_cull_test.sv -----
`default_nettype none
// Path: a request is written into the queue, then passes the product,
// cut and result registers of the back pipeline before result valid.
// Throughput: one request per cycle while results are accepted; 18 parallel
// 32x32 multipliers, one per plane and axis, set the stage that reads the planes.
// Reset: synchronous, active low; clears the queue, pipeline valids and all
// planes to zero. Loads give no result.
module frustum_cull_test (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire [231:0]  s_axis_tdata,  // plane_index[2:0], ax, ay, az, bx, by, bz, scalar, pad
    input  wire [2:0]    s_axis_tuser,  // command[1:0], box_null[2]
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    output logic [7:0]   m_axis_tdata   // visible[0], culled_plane[3:1], pad
);

    fcull_pkg::t_req in_req, q_req;
    fcull_pkg::t_res res;
    logic q_valid, q_pop;

    assign in_req.command     = s_axis_tuser[1:0];
    assign in_req.box_null    = s_axis_tuser[2];
    assign in_req.plane_index = s_axis_tdata[2:0];
    assign in_req.ax          = s_axis_tdata[34:3];
    assign in_req.ay          = s_axis_tdata[66:35];
    assign in_req.az          = s_axis_tdata[98:67];
    assign in_req.bx          = s_axis_tdata[130:99];
    assign in_req.by          = s_axis_tdata[162:131];
    assign in_req.bz          = s_axis_tdata[194:163];
    assign in_req.scalar      = s_axis_tdata[226:195];

    fcull_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_req   (in_req),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_req   (q_req)
    );

    fcull_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_pop   (q_pop),
        .i_req   (q_req),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (res)
    );

    assign m_axis_tdata = {4'b0, res.culled_plane, res.visible};

`ifndef ASSERT_OFF
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");
    a_vis_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[3:1] == fcull_pkg::NONE_CODE)
        else $error("visible result names a culling plane");
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[7:4] == 4'b0)
        else $error("result padding not zero");
`endif

endmodule
`default_nettype wire

// ----- hdl/fcull_front.sv -----
`default_nettype none
module fcull_front (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_ready,
    input  fcull_pkg::t_req   i_req,
    output logic              o_valid,
    input  wire               i_pop,
    output fcull_pkg::t_req   o_req
);

    fcull_pkg::t_req r_mem [fcull_pkg::FIFO_DEPTH];
    logic [fcull_pkg::FIFO_AW-1:0] r_wp, r_rp;
    logic [fcull_pkg::FIFO_AW:0]   r_cnt;
    logic push, pop;

    assign o_ready = (r_cnt != (fcull_pkg::FIFO_AW+1)'(fcull_pkg::FIFO_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign push    = i_valid && o_ready;
    assign pop     = i_pop && o_valid;
    assign o_req   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (fcull_pkg::FIFO_AW+1)'(push) - (fcull_pkg::FIFO_AW+1)'(pop);
        end
    end

endmodule
`default_nettype wire

// ----- hdl/fcull_back.sv -----
`default_nettype none
module fcull_back (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_pop,
    input  fcull_pkg::t_req   i_req,
    output logic              o_valid,
    input  wire               i_ready,
    output fcull_pkg::t_res   o_res
);

    localparam int NP = fcull_pkg::NUM_PLANES;
    localparam int CW = fcull_pkg::COORD_W;
    localparam int PW = fcull_pkg::PROD_W;
    localparam int AW = fcull_pkg::ACC_W;

    logic signed [CW-1:0] r_plane [NP][4];

    logic en;
    logic r_s1_v, r_s2_v, r_ov;
    logic r_s1_null, r_s2_null;
    logic signed [PW-1:0] r_prod [NP][3];
    logic signed [PW-1:0] n_prod [NP][3];
    logic signed [CW:0]   r_ext  [NP];
    logic signed [CW:0]   n_ext  [NP];
    logic [NP-1:0] r_cut, n_cut;
    fcull_pkg::t_res r_res, n_res;

    assign en      = !r_ov || i_ready;
    assign o_pop   = en;
    assign o_valid = r_ov;
    assign o_res   = r_res;

    always_comb begin
        logic signed [CW-1:0] av [3];
        logic signed [CW-1:0] bv [3];
        logic signed [CW-1:0] v;
        av[0] = i_req.ax; av[1] = i_req.ay; av[2] = i_req.az;
        bv[0] = i_req.bx; bv[1] = i_req.by; bv[2] = i_req.bz;
        for (int p = 0; p < NP; p++) begin
            for (int k = 0; k < 3; k++) begin
                v = av[k];
                if (i_req.command == fcull_pkg::CMD_BOX) begin
                    if (r_plane[p][k][CW-1]) v = (bv[k] < av[k]) ? bv[k] : av[k];
                    else                     v = (bv[k] > av[k]) ? bv[k] : av[k];
                end
                n_prod[p][k] = PW'(r_plane[p][k]) * PW'(v);
            end
            if (i_req.command == fcull_pkg::CMD_SPHERE)
                n_ext[p] = (CW+1)'(r_plane[p][3]) + (CW+1)'(i_req.scalar);
            else
                n_ext[p] = (CW+1)'(r_plane[p][3]);
        end
    end

    always_comb begin
        logic signed [AW-1:0] acc;
        for (int p = 0; p < NP; p++) begin
            acc = AW'(r_prod[p][0]) + AW'(r_prod[p][1]) + AW'(r_prod[p][2])
                + (AW'(r_ext[p]) <<< fcull_pkg::FRAC_BITS);
            n_cut[p] = acc[AW-1];
        end
    end

    always_comb begin
        n_res.visible      = !r_s2_null && (r_cut == '0);
        n_res.culled_plane = fcull_pkg::NONE_CODE;
        if (!r_s2_null) begin
            for (int p = NP - 1; p >= 0; p--) begin
                if (r_cut[p]) n_res.culled_plane = 3'(p);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < NP; p++) begin
                for (int k = 0; k < 4; k++) r_plane[p][k] <= '0;
            end
        end else if (en && i_valid && i_req.command == fcull_pkg::CMD_LOAD) begin
            for (int p = 0; p < NP; p++) begin
                if (32'(i_req.plane_index) == p) begin
                    r_plane[p][0] <= i_req.ax;
                    r_plane[p][1] <= i_req.ay;
                    r_plane[p][2] <= i_req.az;
                    r_plane[p][3] <= i_req.scalar;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_ov   <= 1'b0;
        end else if (en) begin
            r_s1_v <= i_valid && (i_req.command != fcull_pkg::CMD_LOAD);
            r_s2_v <= r_s1_v;
            r_ov   <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_prod    <= n_prod;
            r_ext     <= n_ext;
            r_s1_null <= (i_req.command == fcull_pkg::CMD_BOX) && i_req.box_null;
            r_cut     <= n_cut;
            r_s2_null <= r_s1_null;
            r_res     <= n_res;
        end
    end

endmodule
`default_nettype wire

// ----- bench/frustum_cull_checker.sv -----
module frustum_cull_checker (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_s_tvalid,
    input  wire          i_s_tready,
    input  wire [231:0]  i_s_tdata,
    input  wire [2:0]    i_s_tuser,
    input  wire          i_m_tvalid,
    input  wire          i_m_tready,
    input  wire [7:0]    i_m_tdata,
    output int           o_fail_count,
    output int           o_pending,
    output int           o_results_seen,
    output int           o_culls_seen
);

    logic signed [fcull_pkg::COORD_W-1:0] planes [fcull_pkg::NUM_PLANES][4];
    fcull_pkg::t_res verdict_q [$];

    task automatic report(input string what);
        $display("frustum_cull_checker: mismatch at %0t: %s", $realtime, what);
        o_fail_count++;
    endtask

    // n.p + (d + extra) * 2^FRAC_BITS < 0, exact at full width
    function automatic bit beyond_plane(input int p, input longint x, input longint y,
                                        input longint z, input longint extra);
        logic signed [127:0] dsum;
        longint n0, n1, n2, dd;
        n0 = planes[p][0];
        n1 = planes[p][1];
        n2 = planes[p][2];
        dd = planes[p][3];
        dsum = 128'(signed'(n0 * x)) + 128'(signed'(n1 * y)) + 128'(signed'(n2 * z))
             + 128'(signed'((dd + extra) * (longint'(1) << fcull_pkg::FRAC_BITS)));
        return dsum < 0;
    endfunction

    function automatic fcull_pkg::t_res cull_verdict(input fcull_pkg::t_req r);
        fcull_pkg::t_res v;
        bit cut;
        longint ax, ay, az, bx, by, bz, rad;
        ax = r.ax; ay = r.ay; az = r.az;
        bx = r.bx; by = r.by; bz = r.bz;
        rad = r.scalar;
        v.visible = 1'b1;
        v.culled_plane = fcull_pkg::NONE_CODE;
        if (r.command == fcull_pkg::CMD_BOX && r.box_null) begin
            v.visible = 1'b0;
            return v;
        end
        for (int p = 0; p < fcull_pkg::NUM_PLANES; p++) begin
            if (r.command == fcull_pkg::CMD_POINT) begin
                cut = beyond_plane(p, ax, ay, az, 0);
            end else if (r.command == fcull_pkg::CMD_SPHERE) begin
                cut = beyond_plane(p, ax, ay, az, rad);
            end else begin
                cut = 1;
                for (int c = 0; c < 8; c++) begin
                    if (!beyond_plane(p, c[0] ? bx : ax, c[1] ? by : ay,
                                      c[2] ? bz : az, 0))
                        cut = 0;
                end
            end
            if (cut) begin
                v.visible = 1'b0;
                v.culled_plane = 3'(p);
                return v;
            end
        end
        return v;
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        o_results_seen = 0;
        o_culls_seen = 0;
        foreach (planes[i, j]) planes[i][j] = '0;
    end

    always @(posedge i_clk) begin
        fcull_pkg::t_req r;
        fcull_pkg::t_res got, want;
        if (i_rst_n) begin
            if (i_m_tvalid && i_m_tready) begin
                got.visible = i_m_tdata[0];
                got.culled_plane = i_m_tdata[3:1];
                o_results_seen++;
                if (!got.visible) o_culls_seen++;
                if (verdict_q.size() == 0) begin
                    report("result with no request waiting");
                end else begin
                    want = verdict_q.pop_front();
                    if (got.visible !== want.visible)
                        report($sformatf("visible %0b, expected %0b", got.visible,
                                         want.visible));
                    if (got.culled_plane !== want.culled_plane)
                        report($sformatf("culled_plane %0d, expected %0d",
                                         got.culled_plane, want.culled_plane));
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                r.command     = i_s_tuser[1:0];
                r.box_null    = i_s_tuser[2];
                r.plane_index = i_s_tdata[2:0];
                r.ax          = i_s_tdata[34:3];
                r.ay          = i_s_tdata[66:35];
                r.az          = i_s_tdata[98:67];
                r.bx          = i_s_tdata[130:99];
                r.by          = i_s_tdata[162:131];
                r.bz          = i_s_tdata[194:163];
                r.scalar      = i_s_tdata[226:195];
                if (r.command == fcull_pkg::CMD_LOAD) begin
                    if (r.plane_index < fcull_pkg::NUM_PLANES) begin
                        planes[r.plane_index][0] = r.ax;
                        planes[r.plane_index][1] = r.ay;
                        planes[r.plane_index][2] = r.az;
                        planes[r.plane_index][3] = r.scalar;
                    end
                end else begin
                    verdict_q.push_back(cull_verdict(r));
                end
            end
        end
        o_pending = verdict_q.size();
    end

endmodule

// ----- bench/tb_top.sv -----
module tb_top;

    localparam int N_RANDOM  = 830;
    localparam int CYCLE_CAP = 300000;

    logic          i_clk;
    logic          i_rst_n;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    logic [231:0]  s_axis_tdata;   // plane_index[2:0], ax, ay, az, bx, by, bz, scalar, pad
    logic [2:0]    s_axis_tuser;   // command[1:0], box_null[2]
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    logic [7:0]    m_axis_tdata;   // visible[0], culled_plane[3:1], pad

    int  fail_count, pending, results_seen, culls_seen;
    int  cycles;
    bit  calm;
    int  sent;

    frustum_cull_test dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    frustum_cull_checker chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_tvalid     (s_axis_tvalid),
        .i_s_tready     (s_axis_tready),
        .i_s_tdata      (s_axis_tdata),
        .i_s_tuser      (s_axis_tuser),
        .i_m_tvalid     (m_axis_tvalid),
        .i_m_tready     (m_axis_tready),
        .i_m_tdata      (m_axis_tdata),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_results_seen (results_seen),
        .o_culls_seen   (culls_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("tb_top: timeout after %0d cycles", cycles);
            $display("tb_top: FAIL");
            $finish;
        end
    end

    function automatic logic [31:0] coord();
        case ($urandom_range(0, 5))
            0:       return $urandom;
            1:       return 32'h8000_0000;
            2:       return 32'h7fff_ffff;
            3:       return 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
            default: return 32'($urandom_range(0, 32'h0400_0000)) - 32'h0200_0000;
        endcase
    endfunction

    task automatic send(input logic [1:0] cmd, input logic [2:0] idx,
                        input logic [31:0] ax, input logic [31:0] ay, input logic [31:0] az,
                        input logic [31:0] bx, input logic [31:0] by, input logic [31:0] bz,
                        input logic [31:0] sc, input logic nul);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, sc, bz, by, bx, az, ay, ax, idx};
        s_axis_tuser  <= {nul, cmd};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sent++;
    endtask

    task automatic load_plane(input logic [2:0] idx, input logic [31:0] nx,
                              input logic [31:0] ny, input logic [31:0] nz,
                              input logic [31:0] d);
        send(fcull_pkg::CMD_LOAD, idx, nx, ny, nz, $urandom, $urandom, $urandom, d,
             1'($urandom));
    endtask

    // receiver back-pressure in bursts
    initial begin
        m_axis_tready = 1'b0;
        @(posedge i_clk);
        forever begin
            if (calm || $urandom_range(0, 3) != 0) begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
            end
        end
    end

    initial begin
        logic [1:0] cmd;
        cycles = 0;
        sent = 0;
        calm = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // all-zero planes never cull
        send(fcull_pkg::CMD_POINT, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             0, 0, 0, 0, 0);
        send(fcull_pkg::CMD_SPHERE, 0, 0, 0, 0, 0, 0, 0, 32'h0000_0001, 0);
        // planes x >= 0, y >= 0, z >= 0, x <= 100.0, one of extremes, one never culling
        load_plane(0, 32'h0001_0000, 0, 0, 0);
        load_plane(1, 0, 32'h0001_0000, 0, 0);
        load_plane(2, 0, 0, 32'h0001_0000, 0);
        load_plane(3, 32'hffff_0000, 0, 0, 32'h0064_0000);
        load_plane(4, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
        load_plane(5, 0, 0, 0, 32'h7fff_ffff);
        load_plane(6, 32'h8000_0000, 0, 0, 32'h8000_0000);  // ignored
        load_plane(7, 32'h8000_0000, 0, 0, 32'h8000_0000);  // ignored
        send(fcull_pkg::CMD_POINT, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
             0, 0, 0, 0, 0);
        send(fcull_pkg::CMD_POINT, 0, 32'hffff_ffff, 0, 0, 0, 0, 0, 0, 0);
        send(fcull_pkg::CMD_POINT, 0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
             0, 0, 0, 0, 0);
        send(fcull_pkg::CMD_POINT, 0, 0, 0, 32'h8000_0000, 0, 0, 0, 0, 0);
        send(fcull_pkg::CMD_SPHERE, 0, 32'hffff_0000, 0, 0, 0, 0, 0, 32'h0002_0000, 0);
        send(fcull_pkg::CMD_SPHERE, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
             0, 0, 0, 32'hffff_0000, 0);  // negative radius
        send(fcull_pkg::CMD_SPHERE, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             0, 0, 0, 32'h7fff_ffff, 0);
        send(fcull_pkg::CMD_BOX, 0, 32'hfff0_0000, 32'hfff0_0000, 32'hfff0_0000,
             32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0, 0);
        send(fcull_pkg::CMD_BOX, 0, 32'hfff0_0000, 0, 0, 32'hffff_0000, 32'h0001_0000,
             32'h0001_0000, 0, 0);
        send(fcull_pkg::CMD_BOX, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000,
             32'hffff_0000, 32'hffff_0000, 32'hffff_0000, 0, 0);  // min above max
        send(fcull_pkg::CMD_BOX, 0, 0, 0, 0, 32'h0001_0000, 32'h0001_0000,
             32'h0001_0000, 0, 1);
        send(fcull_pkg::CMD_POINT, 0, 32'hffff_ffff, 0, 0, 0, 0, 0, 0, 1);
        send(fcull_pkg::CMD_BOX, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0);

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n > N_RANDOM - 120) calm = 1;
            cmd = $urandom_range(0, 9) == 0 ? fcull_pkg::CMD_LOAD
                                            : 2'($urandom_range(1, 3));
            if (cmd == fcull_pkg::CMD_LOAD)
                load_plane(3'($urandom), coord(), coord(), coord(), coord());
            else
                send(cmd, 3'($urandom), coord(), coord(), coord(), coord(), coord(),
                     coord(), coord(), $urandom_range(0, 7) == 0);
        end
        s_axis_tvalid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("tb_top: %0d requests sent, %0d results checked, %0d of them culled",
                 sent, results_seen, culls_seen);
        $display("tb_top: points, spheres, boxes and null boxes against reloaded planes");
        if (fail_count == 0 && pending == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
